[rtl/sktr_pkg.sv]
// Shared types, sizes and codes for the k-smallest tracker.
// No dependencies; imported by every module of the block.
`timescale 1ns / 1ps

package sktr_pkg;

  localparam int unsigned MAX_KEPT = 16;
  localparam int unsigned VALUE_W  = 32;
  localparam int unsigned RANK_W   = 5;
  localparam int unsigned CNT_W    = $clog2(MAX_KEPT + 1);
  localparam int unsigned IDX_W    = (MAX_KEPT > 1) ? $clog2(MAX_KEPT) : 1;
  localparam int unsigned CMP_W    = (RANK_W > CNT_W) ? RANK_W : CNT_W;

  typedef enum logic {
    OP_INSERT = 1'b0,
    OP_QUERY  = 1'b1
  } op_e;

  typedef enum logic [1:0] {
    STATUS_OK       = 2'd0,
    STATUS_EMPTY    = 2'd1,
    STATUS_BAD_RANK = 2'd2
  } status_e;

  // Occupancy of the store
  typedef enum logic [1:0] {
    OCC_EMPTY,
    OCC_FILLING,
    OCC_FULL
  } occ_e;

  // Commands from the controller to the datapath
  typedef struct packed {
    logic             insert;
    logic             query;
    logic             query_ok;
    logic [IDX_W-1:0] rd_idx;
    logic [CNT_W-1:0] count;
  } ctl_cmd_t;

endpackage

[rtl/sktr_datapath.sv]
// Datapath: row of compare-and-shift cells holding the sorted values,
// plus the result value register. Depends on sktr_pkg.
`timescale 1ns / 1ps

module sktr_datapath (
  input  logic                                 clk_i,
  input  sktr_pkg::ctl_cmd_t                   cmd_i,
  input  logic signed [sktr_pkg::VALUE_W-1:0] sample_value_i,
  output logic signed [sktr_pkg::VALUE_W-1:0] statistic_o
);
  import sktr_pkg::*;

  logic signed [VALUE_W-1:0] vals_q [MAX_KEPT];
  logic signed [VALUE_W-1:0] vals_d [MAX_KEPT];
  logic [MAX_KEPT-1:0]       take;
  logic signed [VALUE_W-1:0] statistic_q;
  logic signed [VALUE_W-1:0] statistic_d;

  // A cell takes part when it is empty or holds a value above the new one;
  // the taken cells form a run at the top of the row.
  always_comb begin
    for (int i = 0; i < MAX_KEPT; i++) begin
      take[i] = (CNT_W'(i) >= cmd_i.count) || (sample_value_i < vals_q[i]);
    end
  end

  // Each taken cell loads its lower neighbor, or the new value at the boundary
  always_comb begin
    for (int i = 0; i < MAX_KEPT; i++) begin
      if (!take[i]) begin
        vals_d[i] = vals_q[i];
      end else if (i > 0 && take[(i > 0) ? i - 1 : 0]) begin
        vals_d[i] = vals_q[(i > 0) ? i - 1 : 0];
      end else begin
        vals_d[i] = sample_value_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.insert) begin
      vals_q <= vals_d;
    end
  end

  assign statistic_d = cmd_i.query_ok ? vals_q[cmd_i.rd_idx] : '0;

  always_ff @(posedge clk_i) begin
    if (cmd_i.query) begin
      statistic_q <= statistic_d;
    end
  end

  assign statistic_o = statistic_q;

`ifndef NO_ASSERTIONS
  for (genvar g = 0; g + 1 < MAX_KEPT; g++) begin : g_order_chk
    a_sorted: assert property (@(posedge clk_i)
      (CNT_W'(g + 1) < cmd_i.count) |-> (vals_q[g] <= vals_q[g + 1]))
      else $error("held values out of order");
  end
`endif

endmodule

[rtl/sktr_ctrl.sv]
// Controller: occupancy state machine, held count, query decode and
// result strobe/status registers. Depends on sktr_pkg.
`timescale 1ns / 1ps

module sktr_ctrl (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          start_i,
  input  logic                          operation_i,
  input  logic [sktr_pkg::RANK_W-1:0]   rank_i,
  output logic                          busy_o,
  output sktr_pkg::ctl_cmd_t            cmd_o,
  output logic                          done_o,
  output sktr_pkg::status_e             status_o
);
  import sktr_pkg::*;

  occ_e             state_q, state_d;
  logic [CNT_W-1:0] count_q, count_d;
  logic             done_q, done_d;
  status_e          status_q, status_d;

  logic             accept;
  logic             do_insert;
  logic             do_query;
  logic             rank_ok;
  logic [CMP_W-1:0] rank_ext;
  logic [CMP_W-1:0] count_ext;
  logic [CMP_W-1:0] pick;

  // Every cycle takes a beat
  assign busy_o    = 1'b0;
  assign accept    = start_i && !busy_o;
  assign do_insert = accept && (op_e'(operation_i) == OP_INSERT);
  assign do_query  = accept && (op_e'(operation_i) == OP_QUERY);

  assign rank_ext  = CMP_W'(rank_i);
  assign count_ext = CMP_W'(count_q);
  assign rank_ok   = (rank_i != '0) && (rank_ext <= CMP_W'(MAX_KEPT));
  assign pick      = (rank_ext < count_ext) ? rank_ext : count_ext;

  // Next state
  always_comb begin
    state_d = state_q;
    if (do_insert) begin
      unique case (state_q)
        OCC_EMPTY:   state_d = (MAX_KEPT == 1) ? OCC_FULL : OCC_FILLING;
        OCC_FILLING: state_d = (count_q == CNT_W'(MAX_KEPT - 1)) ? OCC_FULL : OCC_FILLING;
        OCC_FULL:    state_d = OCC_FULL;
        default:     state_d = OCC_EMPTY;
      endcase
    end
  end

  // Outputs and counters
  always_comb begin
    count_d         = count_q;
    done_d          = do_query;
    status_d        = status_q;
    cmd_o.insert    = do_insert;
    cmd_o.query     = do_query;
    cmd_o.query_ok  = 1'b0;
    cmd_o.rd_idx    = IDX_W'(pick - CMP_W'(1));
    cmd_o.count     = count_q;
    unique case (state_q)
      OCC_EMPTY, OCC_FILLING: begin
        if (do_insert) begin
          count_d = count_q + CNT_W'(1);
        end
      end
      OCC_FULL: ;
      default: ;
    endcase
    if (do_query) begin
      if (!rank_ok) begin
        status_d = STATUS_BAD_RANK;
      end else if (state_q == OCC_EMPTY) begin
        status_d = STATUS_EMPTY;
      end else begin
        status_d       = STATUS_OK;
        cmd_o.query_ok = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= OCC_EMPTY;
      count_q  <= '0;
      done_q   <= 1'b0;
      status_q <= STATUS_OK;
    end else begin
      state_q  <= state_d;
      count_q  <= count_d;
      done_q   <= done_d;
      status_q <= status_d;
    end
  end

  assign done_o   = done_q;
  assign status_o = status_q;

`ifndef NO_ASSERTIONS
  a_done_src: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_q |-> $past(start_i && operation_i == OP_QUERY))
    else $error("result strobe without a query beat");
  a_count_max: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CNT_W'(MAX_KEPT))
    else $error("held count above capacity");
  a_state_cnt: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ((state_q == OCC_EMPTY) == (count_q == '0)) &&
    ((state_q == OCC_FULL) == (count_q == CNT_W'(MAX_KEPT))))
    else $error("occupancy state disagrees with held count");
  a_fill_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (do_insert && state_q != OCC_FULL) |=> (count_q == $past(count_q) + CNT_W'(1)))
    else $error("insert into non-full store did not grow count");
`endif

endmodule

[rtl/streaming_k_smallest_tracker_unit.sv]
// Top level of the k-smallest tracker: joins the controller and the datapath.
// Depends on sktr_pkg, sktr_ctrl and sktr_datapath.
`timescale 1ns / 1ps

// Usage
//   Input channel: a beat is taken on a rising edge with start_i high and
//   busy_o low. operation_i selects insert (sample_value_i) or query (rank_i).
//   busy_o stays low: one beat is taken every cycle, as the compare-and-shift
//   row inserts a value in place.
//   Insert: no result; the row holds the smallest MAX_KEPT values, ascending,
//   duplicates after equal ones. When full, a value below the largest pushes
//   the largest out; anything else is dropped.
//   Query: one result beat the cycle after the query beat, done_o high for
//   exactly one cycle with statistic_o and status_o. status_o reports a rank
//   of zero or above MAX_KEPT first (statistic zero), then an empty store
//   (statistic zero); otherwise the rank-th smallest, or the largest held.
//   The receiver cannot stall: each result beat is taken as it appears.
//   Reset (rst_ni low, asynchronous): the store reads as empty, no strobe.
//   Held values themselves are not cleared; the count guards them.
module streaming_k_smallest_tracker_unit (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 start_i,
  output logic                                 busy_o,
  input  logic                                 operation_i,
  input  logic signed [sktr_pkg::VALUE_W-1:0] sample_value_i,
  input  logic [sktr_pkg::RANK_W-1:0]         rank_i,
  output logic                                 done_o,
  output logic signed [sktr_pkg::VALUE_W-1:0] statistic_o,
  output logic [1:0]                           status_o
);
  import sktr_pkg::*;

  ctl_cmd_t cmd;
  status_e  status;

  // Sequence inserts and queries, track occupancy
  sktr_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start_i     (start_i),
    .operation_i (operation_i),
    .rank_i      (rank_i),
    .busy_o      (busy_o),
    .cmd_o       (cmd),
    .done_o      (done_o),
    .status_o    (status)
  );

  // Hold the sorted values and register the picked one
  sktr_datapath u_datapath (
    .clk_i          (clk_i),
    .cmd_i          (cmd),
    .sample_value_i (sample_value_i),
    .statistic_o    (statistic_o)
  );

  assign status_o = status;

endmodule

[tb/streaming_k_smallest_tracker_unit_test.sv]
// Self-checking bench for streaming_k_smallest_tracker_unit: drives insert and query beats,
// keeps its own sorted copy of the smallest values and checks every result beat.
// Depends on sktr_pkg and the streaming_k_smallest_tracker_unit RTL.
`timescale 1ns / 1ps

module streaming_k_smallest_tracker_unit_test;

  import sktr_pkg::*;

  typedef logic signed [VALUE_W-1:0] value_t;

  // Holds a sorted copy of the kept values and the answers still owed by the block.
  class order_stat_board;

    typedef struct {
      value_t  stat;
      status_e status;
    } answer_t;

    value_t      row [MAX_KEPT];
    int unsigned held;
    answer_t     pending_answers [$];
    int unsigned mismatches;

    function new();
      held       = 0;
      mismatches = 0;
    endfunction

    function value_t largest();
      return (held == 0) ? value_t'(0) : row[held-1];
    endfunction

    function int unsigned owed();
      return pending_answers.size();
    endfunction

    // Apply one accepted beat: insert in place, or queue the answer to a query.
    function void take_beat(op_e op, value_t v, logic [RANK_W-1:0] rnk);
      int unsigned pos;
      int unsigned idx;
      answer_t     ans;
      if (op == OP_INSERT) begin
        if (held < MAX_KEPT) begin
          pos  = held;
          held = held + 1;
        end else if (!(row[MAX_KEPT-1] > v)) begin
          return;
        end else begin
          pos = MAX_KEPT - 1;
        end
        while (pos > 0 && row[pos-1] > v) begin
          row[pos] = row[pos-1];
          pos      = pos - 1;
        end
        row[pos] = v;
      end else begin
        ans.stat   = '0;
        ans.status = STATUS_OK;
        if (rnk == 0 || rnk > MAX_KEPT) begin
          ans.status = STATUS_BAD_RANK;
        end else if (held == 0) begin
          ans.status = STATUS_EMPTY;
        end else begin
          idx      = (rnk < held) ? rnk : held;
          ans.stat = row[idx-1];
        end
        pending_answers = {pending_answers, ans};
      end
    endfunction

    task report_mismatch(string what);
      $display("MISMATCH @%0t: %s", $realtime, what);
      mismatches = mismatches + 1;
    endtask

    task match_answer(value_t stat, logic [1:0] status);
      answer_t ans;
      if (pending_answers.size() == 0) begin
        report_mismatch($sformatf("result beat with no query waiting (stat %0d status %0d)",
                                  stat, status));
      end else begin
        ans = pending_answers.pop_front();
        if (stat !== ans.stat)
          report_mismatch($sformatf("statistic %0d, want %0d", stat, ans.stat));
        if (status !== ans.status)
          report_mismatch($sformatf("status %0d, want %0d", status, ans.status));
      end
    endtask

  endclass

  logic                clk_i;
  logic                rst_ni;
  logic                start_i;
  logic                busy_o;
  logic                operation_i;
  value_t              sample_value_i;
  logic [RANK_W-1:0]   rank_i;
  logic                done_o;
  value_t              statistic_o;
  logic [1:0]          status_o;

  order_stat_board board = new();

  streaming_k_smallest_tracker_unit u_dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .start_i        (start_i),
    .busy_o         (busy_o),
    .operation_i    (operation_i),
    .sample_value_i (sample_value_i),
    .rank_i         (rank_i),
    .done_o         (done_o),
    .statistic_o    (statistic_o),
    .status_o       (status_o)
  );

  initial clk_i = 1'b0;
  always #10 clk_i = ~clk_i;

  // Watch both channels at the rising edge in one process, result first, so the
  // order of checking never depends on scheduling. A query taken at this edge
  // is answered only after it, so its answer is queued in time.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (done_o)
        board.match_answer(statistic_o, status_o);
      if (start_i && !busy_o)
        board.take_beat(op_e'(operation_i), sample_value_i, rank_i);
    end
  end

  // Send one beat: idle at random first, with junk on the fields, then hold
  // start until the handshake lands, and drop it at the next falling edge.
  task automatic send_item(op_e op, value_t v, logic [RANK_W-1:0] rnk, int unsigned idle_pct);
    while ($urandom_range(99) < idle_pct) begin
      start_i        = 1'b0;
      sample_value_i = $urandom;
      rank_i         = RANK_W'($urandom);
      @(negedge clk_i);
    end
    start_i        = 1'b1;
    operation_i    = op;
    sample_value_i = v;
    rank_i         = rnk;
    do @(posedge clk_i); while (busy_o);
    @(negedge clk_i);
    start_i = 1'b0;
  endtask

  // Hold the sender off until every owed answer has come back.
  task automatic drain_answers();
    start_i = 1'b0;
    while (board.owed() != 0) @(posedge clk_i);
    @(negedge clk_i);
  endtask

  // One random beat. Inserts mix full-range values, a narrow band that makes
  // duplicates, values around and just below the current largest so a full
  // store keeps pushing values out, and the two extremes.
  task automatic send_random(int unsigned idle_pct);
    op_e               op;
    value_t            v;
    logic [RANK_W-1:0] rnk;
    op  = ($urandom_range(99) < 55) ? OP_INSERT : OP_QUERY;
    rnk = ($urandom_range(99) < 85) ? RANK_W'($urandom_range(MAX_KEPT, 1))
                                    : RANK_W'($urandom_range(31));
    case ($urandom_range(9))
      0, 1, 2, 3: v = $urandom;
      4, 5:       v = value_t'($urandom_range(40)) - 20;
      6, 7:       v = board.largest() + value_t'($urandom_range(4)) - 2;
      8:          v = $urandom_range(1) ? 32'sh7FFF_FFFF : 32'sh8000_0000;
      default:    v = board.largest() - value_t'($urandom_range(1000));
    endcase
    send_item(op, v, rnk, idle_pct);
  endtask

  initial begin
    rst_ni         = 1'b0;
    start_i        = 1'b0;
    operation_i    = OP_INSERT;
    sample_value_i = '0;
    rank_i         = '0;
    repeat (5) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    // Empty store: a bad rank wins over the empty report.
    send_item(OP_QUERY, '0, 5'd0, 0);
    send_item(OP_QUERY, '0, 5'd1, 0);
    send_item(OP_QUERY, '1, 5'd31, 0);
    send_item(OP_QUERY, '0, 5'd16, 0);
    send_item(OP_QUERY, '0, 5'd17, 0);

    // Extremes, then a rank beyond the held count returns the largest.
    send_item(OP_INSERT, 32'sh7FFF_FFFF, 5'd0, 0);
    send_item(OP_INSERT, 32'sh8000_0000, 5'd31, 0);
    send_item(OP_QUERY, '0, 5'd1, 0);
    send_item(OP_QUERY, '0, 5'd16, 0);

    // Duplicates land after equal values.
    send_item(OP_INSERT, 32'sd0, 5'd0, 0);
    send_item(OP_INSERT, 32'sd0, 5'd0, 0);
    send_item(OP_INSERT, -32'sd1, 5'd0, 0);
    send_item(OP_QUERY, '0, 5'd3, 0);

    // Fill the store, offer a value equal to the largest (dropped), then one
    // below it that pushes the largest out.
    for (int i = 1; i <= 11; i++)
      send_item(OP_INSERT, value_t'(i * 1000), 5'd0, 0);
    send_item(OP_INSERT, 32'sh7FFF_FFFF, 5'd0, 0);
    send_item(OP_QUERY, '0, 5'd16, 0);
    send_item(OP_INSERT, -32'sd5, 5'd0, 0);
    send_item(OP_QUERY, '0, 5'd16, 0);

    // Random part in three phases of sender idling, with full drains between.
    repeat (300) send_random(26);
    drain_answers();
    repeat (300) send_random(77);
    drain_answers();
    repeat (300) send_random(0);

    // Wait out the last answers, then leave slack for stray beats.
    start_i = 1'b0;
    while (board.owed() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);

    if (board.mismatches == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

  // Hard stop well beyond the slowest legal run.
  initial begin
    #4_000_000;
    $display("end of test: mismatches");
    $finish;
  end

endmodule
